// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker of the reply parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ACRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ACRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/acrp_pkg.sv =====
// Types and constants of the acknowledge reply byte parser.
`timescale 1ns / 1ps

package acrp_pkg;

  // Number of option fields that header flag bits can mark.
  localparam int OPTION_FIELDS = 6;
  // Width of the option field index.
  localparam int OI_W = 3;
  // Width of a byte position within a reply.
  localparam int POS_W = 11;
  // Smallest body length that still covers the type and code bytes.
  localparam logic [7:0] BODY_MIN = 8'd6;
  // Body position of the type byte and of the ack code byte.
  localparam logic [POS_W:0] TYPE_POS = (POS_W + 1)'(1);
  localparam logic [POS_W:0] CODE_POS = (POS_W + 1)'(5);

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN_REPLY_SIZE = 2'd0;
  localparam logic [1:0] CFG_OPTIONS_FLAG_MASK = 2'd1;
  localparam logic [1:0] CFG_ACK_TYPE_CODE = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] MIN_REPLY_SIZE_RST = 8'd6;
  localparam logic [7:0] OPTIONS_FLAG_MASK_RST = 8'd128;
  localparam logic [7:0] ACK_TYPE_CODE_RST = 8'd1;

  typedef enum logic [1:0] {
    STATUS_NEED_MORE = 2'd0,
    STATUS_ACK       = 2'd1,
    STATUS_NAK       = 2'd2,
    STATUS_ERROR     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] nak_code;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] min_reply_size;
    logic [7:0] options_flag_mask;
    logic [7:0] ack_type_code;
  } cfg_regs_t;

endpackage

// ===== rtl/core/acrp_parse_core.sv =====
// Parse state registers and the per-byte update and verdict logic.
`timescale 1ns / 1ps

module acrp_parse_core import acrp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_beat_t  beat,
  input  cfg_regs_t cfg,
  output out_beat_t result
);

  typedef struct packed {
    logic            found;
    logic [OI_W-1:0] idx;
  } seek_t;

  // Lowest flagged option field at or above the start index.
  function automatic seek_t seek_option(input logic [7:0] flags, input logic [OI_W-1:0] start);
    seek_t s;
    s.found = 1'b0;
    s.idx   = '0;
    for (int i = OPTION_FIELDS - 1; i >= 0; i--) begin
      if (OI_W'(i) >= start && flags[i]) begin
        s.found = 1'b1;
        s.idx   = OI_W'(i);
      end
    end
    return s;
  endfunction

  logic [POS_W-1:0] bytes_seen_r, bytes_seen_nxt;
  logic [7:0]       header_flags_r, header_flags_nxt;
  logic [OI_W-1:0]  option_index_r, option_index_nxt;
  logic [POS_W-1:0] next_marker_pos_r, next_marker_pos_nxt;
  logic [POS_W-1:0] body_offset_r, body_offset_nxt;
  logic             type_mismatch_r, type_mismatch_nxt;
  logic             in_body_r, in_body_nxt;
  logic [7:0]       ack_code_r, ack_code_nxt;

  logic [POS_W-1:0] pos;
  logic [POS_W:0]   target;
  logic [7:0]       need;
  logic             verdict;
  seek_t            seek_first;
  seek_t            seek_next;

  // Option search for the header byte and for the field after the current one.
  assign seek_first = seek_option(beat.rx_byte, '0);
  assign seek_next  = seek_option(beat.restart ? 8'd0 : header_flags_r,
                                  option_index_r + OI_W'(1));

  // Effective minimum body length.
  assign need = (cfg.min_reply_size < BODY_MIN) ? BODY_MIN : cfg.min_reply_size;

  // Next parse state and the result for this byte.
  always_comb begin
    pos                 = beat.restart ? '0 : bytes_seen_r;
    header_flags_nxt    = beat.restart ? '0 : header_flags_r;
    option_index_nxt    = beat.restart ? '0 : option_index_r;
    next_marker_pos_nxt = beat.restart ? '0 : next_marker_pos_r;
    body_offset_nxt     = beat.restart ? '0 : body_offset_r;
    type_mismatch_nxt   = beat.restart ? 1'b0 : type_mismatch_r;
    in_body_nxt         = beat.restart ? 1'b0 : in_body_r;
    ack_code_nxt        = beat.restart ? '0 : ack_code_r;
    target              = {1'b0, pos} + {4'd0, beat.rx_byte} + (POS_W + 1)'(1);
    verdict             = 1'b0;

    if (pos == '0) begin
      // Header byte: find the first flagged option or start the body.
      header_flags_nxt = beat.rx_byte;
      option_index_nxt = '0;
      if ((beat.rx_byte & cfg.options_flag_mask) != 8'd0) begin
        if (seek_first.found) begin
          option_index_nxt    = seek_first.idx;
          next_marker_pos_nxt = POS_W'(1);
        end else begin
          in_body_nxt     = 1'b1;
          body_offset_nxt = POS_W'(1);
        end
      end else begin
        in_body_nxt     = 1'b1;
        body_offset_nxt = '0;
      end
    end else if (!in_body_nxt && pos == next_marker_pos_nxt) begin
      // Option length byte: skip the field and look for the next one.
      if (seek_next.found) begin
        option_index_nxt    = seek_next.idx;
        next_marker_pos_nxt = target[POS_W-1:0];
      end else begin
        option_index_nxt = option_index_nxt + OI_W'(1);
        in_body_nxt      = 1'b1;
        body_offset_nxt  = target[POS_W-1:0];
      end
    end

    // Body bytes: capture type check and ack code, then test for the verdict.
    if (in_body_nxt) begin
      if ({1'b0, pos} == {1'b0, body_offset_nxt} + TYPE_POS) begin
        type_mismatch_nxt = (beat.rx_byte != cfg.ack_type_code);
      end
      if ({1'b0, pos} == {1'b0, body_offset_nxt} + CODE_POS) begin
        ack_code_nxt = beat.rx_byte;
      end
      if ({1'b0, pos} >= {1'b0, body_offset_nxt} + {4'd0, need} - (POS_W + 1)'(1)) begin
        verdict = 1'b1;
      end
    end

    // Result fields.
    result.status   = STATUS_NEED_MORE;
    result.nak_code = '0;
    if (verdict) begin
      if (type_mismatch_nxt) begin
        result.status = STATUS_ERROR;
      end else if (ack_code_nxt == 8'd0) begin
        result.status = STATUS_ACK;
      end else begin
        result.status   = STATUS_NAK;
        result.nak_code = ack_code_nxt;
      end
    end

    // A verdict restarts the parse with the next byte.
    if (verdict) begin
      bytes_seen_nxt      = '0;
      header_flags_nxt    = '0;
      option_index_nxt    = '0;
      next_marker_pos_nxt = '0;
      body_offset_nxt     = '0;
      type_mismatch_nxt   = 1'b0;
      in_body_nxt         = 1'b0;
      ack_code_nxt        = '0;
    end else begin
      bytes_seen_nxt = pos + POS_W'(1);
    end
  end

  // Parse state registers, updated once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r      <= '0;
      header_flags_r    <= '0;
      option_index_r    <= '0;
      next_marker_pos_r <= '0;
      body_offset_r     <= '0;
      type_mismatch_r   <= 1'b0;
      in_body_r         <= 1'b0;
      ack_code_r        <= '0;
    end else if (step) begin
      bytes_seen_r      <= bytes_seen_nxt;
      header_flags_r    <= header_flags_nxt;
      option_index_r    <= option_index_nxt;
      next_marker_pos_r <= next_marker_pos_nxt;
      body_offset_r     <= body_offset_nxt;
      type_mismatch_r   <= type_mismatch_nxt;
      in_body_r         <= in_body_nxt;
      ack_code_r        <= ack_code_nxt;
    end
  end

endmodule

// ===== rtl/core/ack_reply_byte_parser.sv =====
// Top level of the acknowledge reply byte parser.
// Flow: a byte accepted into the input register has its result written to the output register
// once that register is free or being drained, and out_valid rises with that write.
// Throughput: one byte per cycle while out_ready holds, set by the single input register to output register pass.
// Reset: synchronous active-low rst_n clears the parse state and both valid flags and loads
// the configuration defaults (minimum size 6, flag mask 128, ack type 1).
`timescale 1ns / 1ps

module ack_reply_byte_parser import acrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic      in_valid_r, in_valid_nxt;
  in_beat_t  in_beat_r;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r;
  cfg_regs_t cfg_r;
  out_beat_t result;
  logic      accept;
  logic      advance;

  // Handshake: the held byte moves on whenever the output register is free.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    in_valid_nxt  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_beat_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_reply_size    <= MIN_REPLY_SIZE_RST;
      cfg_r.options_flag_mask <= OPTIONS_FLAG_MASK_RST;
      cfg_r.ack_type_code     <= ACK_TYPE_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_REPLY_SIZE:    cfg_r.min_reply_size    <= cfg_wdata;
        CFG_OPTIONS_FLAG_MASK: cfg_r.options_flag_mask <= cfg_wdata;
        CFG_ACK_TYPE_CODE:     cfg_r.ack_type_code     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  acrp_parse_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .beat   (in_beat_r),
    .cfg    (cfg_r),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/acrp_checker.sv =====
// Port-level checker for the acknowledge reply byte parser and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module acrp_checker import acrp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input out_beat_t  out_data
);

  // A stalled result beat holds.
  `ACRP_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_data),
    "result beat changed while stalled")

  // The code field is nonzero exactly on a nak.
  `ACRP_ASSERT(a_nak_code,
    out_valid |-> ((out_data.status == STATUS_NAK) == (out_data.nak_code != 8'd0)),
    "nak code does not match status")

  // An empty output register never blocks the input.
  `ACRP_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

  // Reset empties the output.
  `ACRP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind ack_reply_byte_parser acrp_checker u_acrp_checker (.*);
